>>> design/hpd_pkg.sv
package hpd_pkg;

  // packet geometry
  localparam int unsigned MaxPacketChars = 4096;
  localparam int unsigned PosW           = $clog2(MaxPacketChars + 1);
  localparam int unsigned MinPacketChars = 12;
  localparam int unsigned DelayDepth     = 4;
  localparam int unsigned PrefixChars    = 2;
  localparam int unsigned HeaderChars    = 8;

  localparam logic [7:0] CharPrefix = 8'h61;  // 'a'
  localparam logic [7:0] CharZero   = 8'h30;  // '0'

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusShort    = 3'd1,
    StatusChecksum = 3'd2,
    StatusDigit    = 3'd3,
    StatusTooLong  = 3'd4
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       packet_done;
    logic [7:0] sender_id;
    logic [7:0] receiver_id;
    logic [7:0] header_code;
    status_e    status;
  } result_t;

  // ascii hex digit to nibble, any case
  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.nib = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // nibble to lowercase ascii hex
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h57 + {4'd0, v};
    end
    return r;
  endfunction

endpackage

>>> design/hpd_if.sv
interface hpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface hpd_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          data_byte;
  logic                data_valid;
  logic                packet_done;
  logic [7:0]          sender_id;
  logic [7:0]          receiver_id;
  logic [7:0]          header_code;
  hpd_pkg::status_e    status;

  modport source (
    output valid, output data_byte, output data_valid, output packet_done,
    output sender_id, output receiver_id, output header_code, output status,
    input ready
  );
  modport sink (
    input valid, input data_byte, input data_valid, input packet_done,
    input sender_id, input receiver_id, input header_code, input status,
    output ready
  );
endinterface

>>> design/hex_packet_deframer.sv
// ascii hex packet deframer: takes one character per request, last_char on the
// final one, and decodes "aa", sender, receiver and header hex pairs, then data
// pairs, with a trailing "00xx" additive checksum. every character is judged
// four characters late, so a data byte is put in the result register by the request
// that pushes its second digit out of the delay line; a byte may thus go out before
// the checksum is known and must be dropped downstream when the closing status
// is not ok. the closing request yields one result with packet_done, the three
// fields (zero unless ok) and the status. throughput is one character per
// cycle, each result passing through the result register; the input is
// only held off while a result sits in that register and the sink is stalled.
// characters after the first MaxPacketChars are counted as overflow only.
module hex_packet_deframer (
  input  logic clk_i,
  input  logic rst_ni,
  hpd_in_if.sink    in_i,
  hpd_out_if.source out_o
);

  localparam int unsigned PosW = hpd_pkg::PosW;

  // packet state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      delay_q [hpd_pkg::DelayDepth];
  logic [7:0]      delay_d [hpd_pkg::DelayDepth];
  logic [7:0]      sum_q, sum_d;
  logic [3:0]      hi_q, hi_d;
  logic [7:0]      field_q [3];
  logic [7:0]      field_d [3];
  logic            prefix_ok_q, prefix_ok_d;
  logic            digit_bad_q, digit_bad_d;
  logic            ovf_q, ovf_d;

  // result register
  logic              out_valid_q;
  hpd_pkg::result_t  res_q, res_d;
  logic              res_present;

  logic              in_fire;

  // step decode
  logic                  pos_ovf;
  logic                  body;
  logic                  is_digit;
  logic [PosW-1:0]       q;
  logic [7:0]            b;
  hpd_pkg::hex_digit_t   hd;
  logic [7:0]            value;
  logic                  emit;
  logic                  too_short;
  hpd_pkg::status_e      status;

  // a new character goes in whenever the result register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    pos_ovf  = pos_q >= PosW'(hpd_pkg::MaxPacketChars);
    body     = !pos_ovf && (pos_q >= PosW'(hpd_pkg::DelayDepth));
    q        = pos_q - PosW'(hpd_pkg::DelayDepth);
    b        = delay_q[0];
    hd       = hpd_pkg::hex_value(b);
    is_digit = body && (q >= PosW'(hpd_pkg::PrefixChars));
    value    = {hi_q, hd.nib};
    emit     = is_digit && q[0] && (q >= PosW'(hpd_pkg::HeaderChars));

    // next state, before the end-of-packet clear
    sum_d       = body ? sum_q + b : sum_q;
    prefix_ok_d = prefix_ok_q &&
                  !(body && (q < PosW'(hpd_pkg::PrefixChars)) && (b != hpd_pkg::CharPrefix));
    digit_bad_d = digit_bad_q || (is_digit && !hd.ok);
    hi_d        = (is_digit && !q[0]) ? hd.nib : hi_q;
    field_d     = field_q;
    if (is_digit && q[0] && (q < PosW'(hpd_pkg::HeaderChars))) begin
      // odd digit positions 3, 5, 7 fill sender, receiver, header
      field_d[q[2:1] - 2'd1] = value;
    end
    ovf_d = ovf_q || pos_ovf;
    pos_d = pos_ovf ? pos_q : pos_q + PosW'(1);
    for (int i = 0; i < hpd_pkg::DelayDepth - 1; i++) begin
      delay_d[i] = delay_q[i+1];
    end
    delay_d[hpd_pkg::DelayDepth-1] = in_i.char_in;

    // closing status, priority short/prefix, too long, checksum, digit
    too_short = !ovf_d && (pos_q < PosW'(hpd_pkg::MinPacketChars - 1));
    if (too_short || !prefix_ok_d) begin
      status = hpd_pkg::StatusShort;
    end else if (ovf_d) begin
      status = hpd_pkg::StatusTooLong;
    end else if (delay_d[0] != hpd_pkg::CharZero || delay_d[1] != hpd_pkg::CharZero ||
                 delay_d[2] != hpd_pkg::hex_char(sum_d[7:4]) ||
                 delay_d[3] != hpd_pkg::hex_char(sum_d[3:0])) begin
      status = hpd_pkg::StatusChecksum;
    end else if (digit_bad_d) begin
      status = hpd_pkg::StatusDigit;
    end else begin
      status = hpd_pkg::StatusOk;
    end

    res_present       = emit || in_i.last_char;
    res_d.data_byte   = emit ? value : 8'd0;
    res_d.data_valid  = emit;
    res_d.packet_done = in_i.last_char;
    res_d.status      = in_i.last_char ? status : hpd_pkg::StatusOk;
    if (in_i.last_char && status == hpd_pkg::StatusOk) begin
      res_d.sender_id   = field_d[0];
      res_d.receiver_id = field_d[1];
      res_d.header_code = field_d[2];
    end else begin
      res_d.sender_id   = 8'd0;
      res_d.receiver_id = 8'd0;
      res_d.header_code = 8'd0;
    end
  end

  // packet state: cleared after every closing character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      hi_q        <= '0;
      prefix_ok_q <= 1'b1;
      digit_bad_q <= 1'b0;
      ovf_q       <= 1'b0;
      for (int i = 0; i < hpd_pkg::DelayDepth; i++) delay_q[i] <= '0;
      for (int i = 0; i < 3; i++) field_q[i] <= '0;
    end else if (in_fire) begin
      if (in_i.last_char) begin
        pos_q       <= '0;
        sum_q       <= '0;
        hi_q        <= '0;
        prefix_ok_q <= 1'b1;
        digit_bad_q <= 1'b0;
        ovf_q       <= 1'b0;
        for (int i = 0; i < hpd_pkg::DelayDepth; i++) delay_q[i] <= '0;
        for (int i = 0; i < 3; i++) field_q[i] <= '0;
      end else begin
        pos_q       <= pos_d;
        sum_q       <= sum_d;
        hi_q        <= hi_d;
        prefix_ok_q <= prefix_ok_d;
        digit_bad_q <= digit_bad_d;
        ovf_q       <= ovf_d;
        delay_q     <= delay_d;
        field_q     <= field_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_present;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_byte   = res_q.data_byte;
  assign out_o.data_valid  = res_q.data_valid;
  assign out_o.packet_done = res_q.packet_done;
  assign out_o.sender_id   = res_q.sender_id;
  assign out_o.receiver_id = res_q.receiver_id;
  assign out_o.header_code = res_q.header_code;
  assign out_o.status      = res_q.status;

  // checks
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last_char |=> pos_q == '0 && sum_q == '0 && prefix_ok_q)
    else $error("packet state not cleared after last character");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(hpd_pkg::MaxPacketChars))
    else $error("character position past packet limit");

  a_result_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data_valid || out_o.packet_done)
    else $error("empty result presented");

  a_fields_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != hpd_pkg::StatusOk |->
      out_o.sender_id == 8'd0 && out_o.receiver_id == 8'd0 && out_o.header_code == 8'd0)
    else $error("fields reported on a failed packet");

endmodule
